@@ rtl/hdlctx_pkg.sv @@
package hdlctx_pkg;

  localparam int unsigned CHANNELS_DEF = 8;

  localparam logic [7:0]  FLAG_BYTE   = 8'h7e;
  localparam logic [15:0] CRC_POLY    = 16'h8408;
  localparam logic [15:0] CRC_PRESET  = 16'hffff;
  localparam logic [15:0] TOTAL_MAX   = 16'hffff;
  localparam logic [2:0]  STUFF_LIMIT = 3'd5;

  localparam logic [3:0] OPEN_FLAGS_RST  = 4'd4;
  localparam logic [2:0] CLOSE_FLAGS_RST = 3'd2;
  localparam logic [3:0] FLAGS_MAX       = 4'd8;
  localparam logic [3:0] CLOSE_MAX       = 4'd4;

  // configuration register indexes
  localparam logic CFG_OPEN_FLAGS  = 1'b0;
  localparam logic CFG_CLOSE_FLAGS = 1'b1;

  typedef enum logic [1:0] {
    CMD_OPEN  = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_CLOSE = 2'd2,
    CMD_FLAGS = 2'd3
  } cmd_e;

  // per-channel line state
  typedef struct packed {
    logic [2:0]  ones;
    logic        level;
    logic [15:0] crc;
    logic [15:0] total;
  } chan_state_t;

  function automatic logic [3:0] clamp_cnt(logic [3:0] v, logic [3:0] hi);
    logic [3:0] r;
    r = v;
    if (v == 4'd0) begin
      r = 4'd1;
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

endpackage

@@ rtl/hdlctx_if.sv @@
interface hdlctx_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [2:0] channel;
  logic [7:0] data_byte;
  logic       corrupt_fcs;
  logic [3:0] flag_count;
  logic       flush_request;

  modport source (
    output valid, command, channel, data_byte, corrupt_fcs, flag_count, flush_request,
    input  ready
  );
  modport sink (
    input  valid, command, channel, data_byte, corrupt_fcs, flag_count, flush_request,
    output ready
  );
endinterface

interface hdlctx_out_if;
  logic        valid;
  logic        ready;
  logic        line_bit;
  logic [2:0]  out_channel;
  logic        last_of_run;
  logic [15:0] bits_sent;
  logic        flush_out;

  modport source (
    output valid, line_bit, out_channel, last_of_run, bits_sent, flush_out,
    input  ready
  );
  modport sink (
    input  valid, line_bit, out_channel, last_of_run, bits_sent, flush_out,
    output ready
  );
endinterface

@@ rtl/hdlctx_chan_store.sv @@
module hdlctx_chan_store #(
  parameter  int unsigned Channels = hdlctx_pkg::CHANNELS_DEF,
  localparam int unsigned IdxW     = (Channels > 1) ? $clog2(Channels) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [IdxW-1:0]          rd_idx_i,
  output hdlctx_pkg::chan_state_t  rd_state_o,
  input  logic                     we_i,
  input  logic [IdxW-1:0]          wr_idx_i,
  input  hdlctx_pkg::chan_state_t  wr_state_i
);
  import hdlctx_pkg::*;

  chan_state_t state_q [Channels];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Channels; i++) begin
        state_q[i] <= '{ones: 3'd0, level: 1'b0, crc: CRC_PRESET, total: 16'd0};
      end
    end else if (we_i) begin
      state_q[wr_idx_i] <= wr_state_i;
    end
  end

  assign rd_state_o = state_q[rd_idx_i];

endmodule

@@ rtl/hdlc_transmit_framer_top.sv @@
// HDLC transmit framer for up to Channels independent channels. Each input beat is one
// command (open, data byte, close, idle flags) for one channel; the block answers with one
// output beat per NRZI line bit, one bit per cycle unless the output stalls, from a single
// bit sequencer that also steps the CRC-16/X.25 one bit at a time. An accepted command
// occupies the block for its line bits: a data byte is 8 bits plus up to two stuffed zeros,
// open and flags are N flags of 8 bits, close is 16 FCS bits plus up to four stuffed zeros
// and then N flags. The input is not ready while a command is being sent; output back-pressure
// stalls the sequencer bit for bit. Commands to a channel at or above Channels are taken and
// dropped. A configuration write lands at once, so write only while no command is in flight.
module hdlc_transmit_framer_top #(
  parameter int unsigned Channels = hdlctx_pkg::CHANNELS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_index_i,
  input  logic [3:0]       cfg_wdata_i,
  hdlctx_in_if.sink        in_if,
  hdlctx_out_if.source     out_if
);
  import hdlctx_pkg::*;

  localparam int unsigned IdxW = (Channels > 1) ? $clog2(Channels) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DATA,
    S_FLAG
  } state_e;

  // configuration
  logic [3:0] open_flags_q;
  logic [2:0] close_flags_q;

  // sequencer
  state_e      state_q, state_d;
  cmd_e        cmd_q, cmd_d;
  logic [2:0]  ch_q, ch_d;
  logic        flush_q, flush_d;
  logic [15:0] shreg_q, shreg_d;     // bits still to send, LSB first
  logic [4:0]  bits_left_q, bits_left_d;
  logic        stuff_q, stuff_d;     // a stuffed zero is owed
  logic [3:0]  flags_left_q, flags_left_d;
  logic [2:0]  fbit_q, fbit_d;

  // output register
  logic        out_valid_q, out_valid_d;
  logic        out_bit_q, out_bit_d;
  logic [2:0]  out_ch_q, out_ch_d;
  logic        out_last_q, out_last_d;
  logic [15:0] out_total_q, out_total_d;
  logic        out_flush_q, out_flush_d;

  // channel store
  chan_state_t       st_rd, st_wr;
  logic              st_we;
  logic [IdxW-1:0]   rd_idx, in_idx, ch_idx;
  logic [IdxW+2:0]   in_ch_wide, ch_wide;

  logic accept, in_range, step, tx_bit, last, fb;

  assign in_ch_wide = (IdxW+3)'(in_if.channel);
  assign ch_wide    = (IdxW+3)'(ch_q);
  assign in_idx     = in_ch_wide[IdxW-1:0];
  assign ch_idx     = ch_wide[IdxW-1:0];
  assign in_range   = 32'(in_if.channel) < Channels;

  assign in_if.ready = (state_q == S_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  // one line bit per cycle whenever the output register frees up
  assign step        = (state_q != S_IDLE) && (!out_valid_q || out_if.ready);
  // idle: the incoming channel, busy: the channel being sent; reads and writes share it
  assign rd_idx      = (state_q == S_IDLE) ? in_idx : ch_idx;

  hdlctx_chan_store #(
    .Channels (Channels)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (rd_idx),
    .rd_state_o (st_rd),
    .we_i       (st_we),
    .wr_idx_i   (rd_idx),
    .wr_state_i (st_wr)
  );

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_flags_q  <= OPEN_FLAGS_RST;
      close_flags_q <= CLOSE_FLAGS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_OPEN_FLAGS:  open_flags_q  <= cfg_wdata_i;
        CFG_CLOSE_FLAGS: close_flags_q <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    ch_d         = ch_q;
    flush_d      = flush_q;
    shreg_d      = shreg_q;
    bits_left_d  = bits_left_q;
    stuff_d      = stuff_q;
    flags_left_d = flags_left_q;
    fbit_d       = fbit_q;
    st_we        = 1'b0;
    st_wr        = st_rd;
    tx_bit       = 1'b0;
    last         = 1'b0;
    fb           = 1'b0;

    out_valid_d  = out_valid_q && !out_if.ready;
    out_bit_d    = out_bit_q;
    out_ch_d     = out_ch_q;
    out_last_d   = out_last_q;
    out_total_d  = out_total_q;
    out_flush_d  = out_flush_q;

    // command decode; the store write on open/flags lands at the incoming channel
    if (accept && in_range) begin
      cmd_d   = cmd_e'(in_if.command);
      ch_d    = in_if.channel;
      flush_d = in_if.flush_request;
      fbit_d  = 3'd0;
      stuff_d = 1'b0;
      unique case (cmd_e'(in_if.command))
        CMD_OPEN: begin
          st_we        = 1'b1;
          st_wr.ones   = 3'd0;
          st_wr.total  = 16'd0;
          st_wr.crc    = CRC_PRESET;
          flags_left_d = clamp_cnt(open_flags_q, FLAGS_MAX);
          state_d      = S_FLAG;
        end
        CMD_DATA: begin
          shreg_d     = {8'h00, in_if.data_byte};
          bits_left_d = 5'd8;
          state_d     = S_DATA;
        end
        CMD_CLOSE: begin
          shreg_d      = in_if.corrupt_fcs ? st_rd.crc : ~st_rd.crc;
          bits_left_d  = 5'd16;
          flags_left_d = clamp_cnt({1'b0, close_flags_q}, CLOSE_MAX);
          state_d      = S_DATA;
        end
        CMD_FLAGS: begin
          st_we        = 1'b1;
          st_wr.total  = 16'd0;
          flags_left_d = clamp_cnt(in_if.flag_count, FLAGS_MAX);
          state_d      = S_FLAG;
        end
        default: ;
      endcase
    end

    if (step) begin
      st_we = 1'b1;
      unique case (state_q)
        S_DATA: begin
          if (stuff_q) begin
            tx_bit  = 1'b0;
            stuff_d = 1'b0;
          end else begin
            tx_bit      = shreg_q[0];
            shreg_d     = shreg_q >> 1;
            bits_left_d = bits_left_q - 5'd1;
            if (cmd_q == CMD_DATA) begin
              // bit-serial CRC-16/X.25, reflected
              fb        = st_rd.crc[0] ^ tx_bit;
              st_wr.crc = (st_rd.crc >> 1) ^ (fb ? CRC_POLY : 16'h0000);
            end
            if (tx_bit) begin
              if (st_rd.ones == STUFF_LIMIT - 3'd1) begin
                st_wr.ones = 3'd0;
                stuff_d    = 1'b1;
              end else begin
                st_wr.ones = st_rd.ones + 3'd1;
              end
            end else begin
              st_wr.ones = 3'd0;
            end
          end
          if (!stuff_d && bits_left_d == 5'd0) begin
            if (cmd_q == CMD_DATA) begin
              last    = 1'b1;
              state_d = S_IDLE;
            end else begin
              state_d = S_FLAG;
            end
          end
        end
        S_FLAG: begin
          tx_bit = FLAG_BYTE[fbit_q];
          fbit_d = fbit_q + 3'd1;
          if (fbit_q == 3'd7) begin
            st_wr.ones   = 3'd0;
            flags_left_d = flags_left_q - 4'd1;
            if (flags_left_q == 4'd1) begin
              last    = 1'b1;
              state_d = S_IDLE;
            end
          end
        end
        default: ;
      endcase

      // NRZI: toggle on zero
      st_wr.level = st_rd.level ^ ~tx_bit;
      if (st_rd.total != TOTAL_MAX) begin
        st_wr.total = st_rd.total + 16'd1;
      end

      out_valid_d = 1'b1;
      out_bit_d   = st_wr.level;
      out_ch_d    = ch_q;
      out_last_d  = last;
      out_total_d = last ? st_wr.total : 16'd0;
      out_flush_d = last && (cmd_q == CMD_FLAGS) && flush_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      stuff_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stuff_q     <= stuff_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload and counters, no reset needed
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    ch_q         <= ch_d;
    flush_q      <= flush_d;
    shreg_q      <= shreg_d;
    bits_left_q  <= bits_left_d;
    flags_left_q <= flags_left_d;
    fbit_q       <= fbit_d;
    out_bit_q    <= out_bit_d;
    out_ch_q     <= out_ch_d;
    out_last_q   <= out_last_d;
    out_total_q  <= out_total_d;
    out_flush_q  <= out_flush_d;
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.line_bit    = out_bit_q;
  assign out_if.out_channel = out_ch_q;
  assign out_if.last_of_run = out_last_q;
  assign out_if.bits_sent   = out_total_q;
  assign out_if.flush_out   = out_flush_q;

  // a pending non-final bit means the command is still running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_last_q |-> state_q != S_IDLE)
    else $error("non-final bit pending while sequencer idle");

  // flush only rides on the final bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_flush_q |-> out_last_q)
    else $error("flush_out without last_of_run");

  // bit count is reported only on the final bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_total_q != 16'd0) |-> out_last_q)
    else $error("bits_sent on non-final bit");

  // a stuffed zero is owed only while sending stuffed bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stuff_q |-> state_q == S_DATA)
    else $error("stuff pending outside data phase");

endmodule

@@ dv/hdlc_transmit_framer_top_tb.sv @@
module hdlc_transmit_framer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hdlctx_pkg::*;

  localparam int unsigned CHANNELS    = CHANNELS_DEF;
  localparam int unsigned CYCLE_LIMIT = 600_000;
  localparam int unsigned SETTLE_CYC  = 8;

  // one expected or observed line beat
  typedef struct packed {
    logic        line_bit;
    logic [2:0]  chan;
    logic        last;
    logic [15:0] total;
    logic        flush;
  } line_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_index_i;
  logic [3:0] cfg_wdata_i;

  hdlctx_in_if  cmd_if ();
  hdlctx_out_if line_if ();

  hdlc_transmit_framer_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (cmd_if),
    .out_if      (line_if)
  );

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Line model: per-channel copy of the framer state plus the two flag counts.
  // ---------------------------------------------------------------------------
  logic [3:0]  open_cnt_reg;
  logic [2:0]  close_cnt_reg;
  logic [2:0]  chan_ones  [CHANNELS];
  logic        chan_level [CHANNELS];
  logic [15:0] chan_crc   [CHANNELS];
  logic [15:0] chan_total [CHANNELS];

  line_beat_t line_q[$];  // line beats still owed by the block

  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;

  function automatic void clear_line_model();
    open_cnt_reg  = OPEN_FLAGS_RST;
    close_cnt_reg = CLOSE_FLAGS_RST;
    for (int i = 0; i < CHANNELS; i++) begin
      chan_ones[i]  = '0;
      chan_level[i] = 1'b0;
      chan_crc[i]   = CRC_PRESET;
      chan_total[i] = '0;
    end
  endfunction

  // counts of zero become one, anything above the ceiling is cut to it
  function automatic int unsigned flag_reps(logic [3:0] v, int unsigned ceiling);
    if (v == 4'd0) return 1;
    if (v > ceiling) return ceiling;
    return v;
  endfunction

  // NRZI: a zero toggles the level, a one holds it
  function automatic void emit_line_bit(int unsigned ch, logic b);
    line_beat_t beat;
    if (!b) chan_level[ch] = ~chan_level[ch];
    if (chan_total[ch] != TOTAL_MAX) chan_total[ch] = chan_total[ch] + 16'd1;
    beat          = '0;
    beat.line_bit = chan_level[ch];
    beat.chan     = ch[2:0];
    line_q.push_back(beat);
  endfunction

  function automatic void emit_flag(int unsigned ch);
    for (int i = 0; i < 8; i++) emit_line_bit(ch, FLAG_BYTE[i]);
    chan_ones[ch] = '0;
  endfunction

  // LSB first, zero inserted after five ones; run carries across bytes
  function automatic void emit_stuffed(int unsigned ch, logic [7:0] byte_v);
    for (int i = 0; i < 8; i++) begin
      emit_line_bit(ch, byte_v[i]);
      if (byte_v[i]) begin
        chan_ones[ch] = chan_ones[ch] + 3'd1;
        if (chan_ones[ch] >= STUFF_LIMIT) begin
          emit_line_bit(ch, 1'b0);
          chan_ones[ch] = '0;
        end
      end else begin
        chan_ones[ch] = '0;
      end
    end
  endfunction

  // CRC-16/X.25, reflected
  function automatic void fold_fcs_byte(int unsigned ch, logic [7:0] byte_v);
    logic [15:0] c;
    c = chan_crc[ch] ^ {8'h00, byte_v};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    chan_crc[ch] = c;
  endfunction

  function automatic void predict_line_bits(cmd_e cmd, int unsigned ch, logic [7:0] byte_v,
                                            logic corrupt, logic [3:0] fcount, logic flush);
    logic [15:0] fcs;
    int unsigned reps;
    if (ch >= CHANNELS) return;
    case (cmd)
      CMD_OPEN: begin
        chan_ones[ch]  = '0;
        chan_total[ch] = '0;
        chan_crc[ch]   = CRC_PRESET;
        reps = flag_reps(open_cnt_reg, FLAGS_MAX);
        for (int i = 0; i < reps; i++) emit_flag(ch);
      end
      CMD_DATA: begin
        fold_fcs_byte(ch, byte_v);
        emit_stuffed(ch, byte_v);
      end
      CMD_CLOSE: begin
        fcs = corrupt ? chan_crc[ch] : ~chan_crc[ch];
        emit_stuffed(ch, fcs[7:0]);
        emit_stuffed(ch, fcs[15:8]);
        reps = flag_reps({1'b0, close_cnt_reg}, CLOSE_MAX);
        for (int i = 0; i < reps; i++) emit_flag(ch);
      end
      default: begin
        chan_total[ch] = '0;
        reps = flag_reps(fcount, FLAGS_MAX);
        for (int i = 0; i < reps; i++) emit_flag(ch);
      end
    endcase
    // every command on a valid channel produces at least one line bit
    line_q[line_q.size() - 1].last  = 1'b1;
    line_q[line_q.size() - 1].total = chan_total[ch];
    line_q[line_q.size() - 1].flush = (cmd == CMD_FLAGS) ? flush : 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: everything sampled at the rising edge. Config writes and
  // command beats update the model, line beats are checked against it.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : scoreboard
    line_beat_t got;
    line_beat_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_OPEN_FLAGS) open_cnt_reg = cfg_wdata_i;
        else close_cnt_reg = cfg_wdata_i[2:0];
      end
      if (cmd_if.valid && cmd_if.ready) begin
        predict_line_bits(cmd_e'(cmd_if.command), cmd_if.channel, cmd_if.data_byte,
                          cmd_if.corrupt_fcs, cmd_if.flag_count, cmd_if.flush_request);
      end
      if (line_if.valid && line_if.ready) begin
        got = '{line_bit: line_if.line_bit, chan: line_if.out_channel,
                last: line_if.last_of_run, total: line_if.bits_sent,
                flush: line_if.flush_out};
        if (line_q.size() == 0) begin
          fail_count++;
          $display({"%0t: unexpected line beat, expected none, ",
                    "actual bit=%0b ch=%0d last=%0b total=%0d flush=%0b"},
                   $time, got.line_bit, got.chan, got.last, got.total, got.flush);
        end else begin
          want = line_q.pop_front();
          if (got !== want) begin
            fail_count++;
            $display("%0t: line beat mismatch, expected bit=%0b ch=%0d last=%0b total=%0d flush=%0b",
                     $time, want.line_bit, want.chan, want.last, want.total, want.flush);
            $display("%0t:                     actual   bit=%0b ch=%0d last=%0b total=%0d flush=%0b",
                     $time, got.line_bit, got.chan, got.last, got.total, got.flush);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d line beats outstanding", cycle_count,
               line_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Line side ready: random stalls, switchable, plus a long hold-off counted
  // down here when a test asks for one.
  // ---------------------------------------------------------------------------
  bit          in_gaps_on  = 1'b1;
  bit          out_gaps_on = 1'b1;
  int unsigned hold_req    = 0;
  int unsigned hold_left   = 0;

  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      line_if.ready <= 1'b0;
    end else begin
      line_if.ready <= !(out_gaps_on && ($urandom_range(0, 99) < 7));
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // one command beat; returns at the edge where it is taken
  task automatic send_cmd(cmd_e cmd, logic [2:0] ch, logic [7:0] byte_v, logic corrupt,
                          logic [3:0] fcount, logic flush);
    @(negedge clk_i);
    while (in_gaps_on && ($urandom_range(0, 99) < 7)) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_if.valid         <= 1'b1;
    cmd_if.command       <= cmd;
    cmd_if.channel       <= ch;
    cmd_if.data_byte     <= byte_v;
    cmd_if.corrupt_fcs   <= corrupt;
    cmd_if.flag_count    <= fcount;
    cmd_if.flush_request <= flush;
    do @(posedge clk_i); while (!cmd_if.ready);
  endtask

  // drop valid, wait for every owed beat, then let the sequencer go idle
  task automatic settle();
    @(negedge clk_i);
    cmd_if.valid <= 1'b0;
    while (line_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic idx, logic [3:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // open, one byte, close, idle flags
  task automatic short_frame(logic [2:0] ch);
    send_cmd(CMD_OPEN,  ch, 8'h00, 1'b0, 4'd0, 1'b0);
    send_cmd(CMD_DATA,  ch, 8'($urandom), 1'b0, 4'd0, 1'b0);
    send_cmd(CMD_CLOSE, ch, 8'h00, 1'b0, 4'd0, 1'b0);
    send_cmd(CMD_FLAGS, ch, 8'h00, 1'b0, 4'($urandom), 1'b1);
  endtask

  // Random traffic: per-channel frame tracking so most beats form proper
  // open / data... / close sequences; one beat in twelve is pure noise.
  bit          frame_live  [CHANNELS];
  int unsigned frame_bytes [CHANNELS];

  task automatic random_beat();
    logic [2:0] ch;
    cmd_e       cmd;
    ch = 3'($urandom_range(0, CHANNELS - 1));
    if ($urandom_range(0, 11) == 0) begin
      cmd = cmd_e'($urandom_range(0, 3));
    end else if (!frame_live[ch]) begin
      cmd = ($urandom_range(0, 99) < 85) ? CMD_OPEN : CMD_FLAGS;
    end else if (frame_bytes[ch] != 0 && $urandom_range(0, 99) < 15) begin
      cmd = CMD_CLOSE;
    end else begin
      cmd = CMD_DATA;
    end
    case (cmd)
      CMD_OPEN: begin
        frame_live[ch]  = 1'b1;
        frame_bytes[ch] = 0;
      end
      CMD_DATA: frame_bytes[ch]++;
      default:  frame_live[ch] = 1'b0;
    endcase
    // ignored fields stay random so every input bit moves
    send_cmd(cmd, ch, 8'($urandom), 1'($urandom), 4'($urandom), 1'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset config (4 open flags, 2 close flags), byte extremes, stuffing runs
  // across bytes, flag count clamping, traffic with no preceding open
  task automatic test_directed_framing();
    send_cmd(CMD_OPEN,  3'd0, 8'h00, 1'b0, 4'd0, 1'b0);
    send_cmd(CMD_DATA,  3'd0, 8'h00, 1'b0, 4'd0, 1'b0);
    send_cmd(CMD_DATA,  3'd0, 8'hff, 1'b0, 4'd0, 1'b0);
    send_cmd(CMD_DATA,  3'd0, 8'hff, 1'b0, 4'd0, 1'b0);
    send_cmd(CMD_DATA,  3'd0, 8'hf8, 1'b0, 4'd0, 1'b0);  // ones run of five ends the byte, stuffed zero sent with it
    send_cmd(CMD_DATA,  3'd0, 8'h7e, 1'b0, 4'd0, 1'b0);  // flag pattern as data
    send_cmd(CMD_CLOSE, 3'd0, 8'h00, 1'b0, 4'd0, 1'b0);
    send_cmd(CMD_FLAGS, 3'd7, 8'hff, 1'b1, 4'd0, 1'b1);  // zero count -> one flag
    send_cmd(CMD_FLAGS, 3'd7, 8'h00, 1'b0, 4'd15, 1'b0); // above ceiling -> eight
    send_cmd(CMD_DATA,  3'd5, 8'haa, 1'b1, 4'd15, 1'b1); // no open on this channel
    send_cmd(CMD_CLOSE, 3'd5, 8'h55, 1'b1, 4'd7, 1'b1);  // corrupted FCS
    settle();
  endtask

  // both flag counts at zero, at the field maximum, at the ceiling and just above
  task automatic test_flag_config();
    cfg_write(CFG_OPEN_FLAGS, 4'd0);
    cfg_write(CFG_CLOSE_FLAGS, 4'd0);
    short_frame(3'd1);
    settle();
    cfg_write(CFG_OPEN_FLAGS, 4'd15);
    cfg_write(CFG_CLOSE_FLAGS, 4'd15);
    short_frame(3'd2);
    settle();
    cfg_write(CFG_OPEN_FLAGS, 4'd8);
    cfg_write(CFG_CLOSE_FLAGS, 4'd4);
    short_frame(3'd3);
    settle();
    cfg_write(CFG_OPEN_FLAGS, 4'd9);
    cfg_write(CFG_CLOSE_FLAGS, 4'd5);
    short_frame(3'd4);
    settle();
  endtask

  // no gaps on either side
  task automatic test_back_to_back();
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    repeat (60) random_beat();
    settle();
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
  endtask

  // line side held off while commands keep coming, so the input stalls
  task automatic test_line_backpressure();
    hold_req = 400;
    repeat (12) random_beat();
    settle();
  endtask

  // random traffic over several random flag settings
  task automatic test_random_frames();
    for (int phase = 0; phase < 4; phase++) begin
      cfg_write(CFG_OPEN_FLAGS, 4'($urandom));
      cfg_write(CFG_CLOSE_FLAGS, 4'($urandom));
      repeat (90) random_beat();
      settle();
    end
  endtask

  initial begin
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_index_i          = CFG_OPEN_FLAGS;
    cfg_wdata_i          = '0;
    cmd_if.valid         = 1'b0;
    cmd_if.command       = CMD_OPEN;
    cmd_if.channel       = '0;
    cmd_if.data_byte     = '0;
    cmd_if.corrupt_fcs   = 1'b0;
    cmd_if.flag_count    = '0;
    cmd_if.flush_request = 1'b0;
    line_if.ready        = 1'b0;
    clear_line_model();
    for (int i = 0; i < CHANNELS; i++) begin
      frame_live[i]  = 1'b0;
      frame_bytes[i] = 0;
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_framing();
    test_flag_config();
    test_back_to_back();
    test_line_backpressure();
    test_random_frames();

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/hdlctx_pkg.sv
rtl/hdlctx_if.sv
rtl/hdlctx_chan_store.sv
rtl/hdlc_transmit_framer_top.sv
dv/hdlc_transmit_framer_top_tb.sv
